### rtl/wavrp_pkg.sv
// Shared constants, types and helpers for the WAV RIFF header parser.
package wavrp_pkg;

  localparam int unsigned POS_BITS = 32;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_FIELD_BYTES = 32'd16;

  localparam logic [3:0] FMT_IDX_AUDIO = 4'd1;
  localparam logic [3:0] FMT_IDX_CHAN  = 4'd3;
  localparam logic [3:0] FMT_IDX_RATE  = 4'd7;
  localparam logic [3:0] FMT_IDX_BRATE = 4'd11;
  localparam logic [3:0] FMT_IDX_ALIGN = 4'd13;
  localparam logic [3:0] FMT_IDX_BITS  = 4'd15;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [2:0] ST_RATE_BAD  = 3'd3;
  localparam logic [2:0] ST_ALIGN_BAD = 3'd4;
  localparam logic [2:0] ST_MISSING   = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  localparam logic [2:0] SEEN_ALL = 3'b111;

  typedef struct packed {
    logic       hdr_byte;
    logic       form_byte;
    logic       fmt_byte;
    logic       skip_dec;
    logic       pos_inc;
    logic       load_skip_fmt;
    logic       load_skip_size;
    logic       rec_data;
    logic       set_riff;
    logic       set_fmt;
    logic       set_err;
    logic [2:0] err_code;
    logic       mul_prod;
    logic       mul_rate;
    logic       finish;
    logic       trunc;
  } cmd_t;

  typedef struct packed {
    logic hdr_done;
    logic size_zero;
    logic is_riff;
    logic is_fmt;
    logic is_data;
    logic form_done;
    logic is_wave;
    logic fmt_done;
    logic skip_le1;
    logic skip_nz;
    logic rate_ok;
    logic align_ok;
    logic slot_free;
  } sts_t;

  // First byte of the fmt field that a given fmt byte belongs to.
  function automatic logic [3:0] field_start(input logic [3:0] idx);
    logic [3:0] s;
    case (idx)
      4'd0, 4'd1:               s = 4'd0;
      4'd2, 4'd3:               s = 4'd2;
      4'd4, 4'd5, 4'd6, 4'd7:   s = 4'd4;
      4'd8, 4'd9, 4'd10, 4'd11: s = 4'd8;
      4'd12, 4'd13:             s = 4'd12;
      default:                  s = 4'd14;
    endcase
    return s;
  endfunction

endpackage

### rtl/wavrp_if.sv
// Channel interfaces: input byte stream and parse result.
interface wavrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_file;

  modport source(output valid, output stream_byte, output end_of_file, input ready);
  modport sink(input valid, input stream_byte, input end_of_file, output ready);
endinterface

interface wavrp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] format_tag;
  logic [15:0] channel_count;
  logic [31:0] sample_freq;
  logic [15:0] sample_bits;
  logic [31:0] data_offset;
  logic [31:0] data_size;

  modport source(output valid, output status, output format_tag, output channel_count,
                 output sample_freq, output sample_bits, output data_offset,
                 output data_size, input ready);
  modport sink(input valid, input status, input format_tag, input channel_count,
               input sample_freq, input sample_bits, input data_offset,
               input data_size, output ready);
endinterface

### rtl/wavrp_datapath.sv
// Datapath: byte assembly, chunk fields, skip counter, fmt check and result register.
module wavrp_datapath (
  input  logic              clk,
  input  logic              rst,
  input  wavrp_pkg::cmd_t   cmd,
  input  logic [7:0]        in_byte,
  input  logic              out_ready,
  output wavrp_pkg::sts_t   sts,
  output logic              out_valid,
  output logic [2:0]        status,
  output logic [15:0]       format_tag,
  output logic [15:0]       channel_count,
  output logic [31:0]       sample_freq,
  output logic [15:0]       sample_bits,
  output logic [31:0]       data_offset,
  output logic [31:0]       data_size
);
  import wavrp_pkg::*;

  logic [3:0]          cnt;
  logic [31:0]         asm_word;
  logic [31:0]         chunk_id;
  logic [31:0]         skip;
  logic [POS_BITS-1:0] pos;
  logic [31:0]         decl_rate;
  logic [15:0]         decl_align;
  logic [15:0]         f_audio;
  logic [15:0]         f_chan;
  logic [31:0]         f_rate;
  logic [15:0]         f_bits;
  logic [31:0]         d_off;
  logic [31:0]         d_size;
  logic [2:0]          seen;
  logic [2:0]          err;
  logic [31:0]         prod;
  logic [31:0]         rprod;

  logic [31:0]         asm_seq;
  logic [3:0]          fstart;
  logic [1:0]          fshift;
  logic [31:0]         asm_fmt;
  logic [POS_BITS-1:0] pos_plus;
  logic [2:0]          err_next;
  logic [2:0]          seen_next;
  logic [2:0]          fin_status;
  logic                fin_ok;

  assign asm_seq  = asm_word | ({24'b0, in_byte} << {cnt[1:0], 3'b000});
  assign fstart   = field_start(cnt);
  assign fshift   = 2'(cnt - fstart);
  assign asm_fmt  = ((cnt == fstart) ? 32'b0 : asm_word) |
                    ({24'b0, in_byte} << {fshift, 3'b000});
  assign pos_plus = pos + 1'b1;

  assign err_next  = (err == ST_OK && cmd.set_err) ? cmd.err_code : err;
  assign seen_next = seen | {cmd.rec_data, cmd.set_fmt, cmd.set_riff};

  always_comb begin
    if (err_next != ST_OK) begin
      fin_status = err_next;
    end else if (cmd.trunc) begin
      fin_status = ST_TRUNCATED;
    end else if (seen_next != SEEN_ALL) begin
      fin_status = ST_MISSING;
    end else begin
      fin_status = ST_OK;
    end
  end
  assign fin_ok = (fin_status == ST_OK);

  assign sts.hdr_done  = (cnt == 4'd7);
  assign sts.size_zero = (asm_seq == 32'b0);
  assign sts.is_riff   = (chunk_id == TAG_RIFF);
  assign sts.is_fmt    = (chunk_id == TAG_FMT);
  assign sts.is_data   = (chunk_id == TAG_DATA);
  assign sts.form_done = (cnt == 4'd3);
  assign sts.is_wave   = (asm_seq == TAG_WAVE);
  assign sts.fmt_done  = (cnt == FMT_IDX_BITS);
  assign sts.skip_le1  = (skip[31:1] == 31'b0);
  assign sts.skip_nz   = (skip != 32'b0);
  assign sts.rate_ok   = ({3'b000, rprod[31:3]} == decl_rate);
  assign sts.align_ok  = (prod[31:3] == {13'b0, decl_align});
  assign sts.slot_free = !out_valid || out_ready;

  // Control state of the parse.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      cnt      <= '0;
      asm_word <= '0;
      pos      <= '0;
      seen     <= '0;
      err      <= ST_OK;
    end else begin
      err  <= err_next;
      seen <= seen_next;
      if (cmd.pos_inc) begin
        pos <= pos_plus;
      end
      if (cmd.hdr_byte) begin
        if (cnt == 4'd3 || cnt == 4'd7) begin
          asm_word <= '0;
        end else begin
          asm_word <= asm_seq;
        end
        cnt <= (cnt == 4'd7) ? 4'd0 : cnt + 1'b1;
      end else if (cmd.form_byte) begin
        asm_word <= (cnt == 4'd3) ? 32'b0 : asm_seq;
        cnt      <= (cnt == 4'd3) ? 4'd0 : cnt + 1'b1;
      end else if (cmd.fmt_byte) begin
        asm_word <= (cnt == FMT_IDX_BITS) ? 32'b0 : asm_fmt;
        cnt      <= cnt + 1'b1;
      end
    end
  end

  // Chunk fields and check products.
  always_ff @(posedge clk) begin
    if (cmd.hdr_byte && cnt == 4'd3) begin
      chunk_id <= asm_seq;
    end
    if (cmd.load_skip_fmt) begin
      skip <= (asm_seq > FMT_FIELD_BYTES) ? asm_seq - FMT_FIELD_BYTES : 32'b0;
    end else if (cmd.load_skip_size) begin
      skip <= asm_seq;
    end else if (cmd.skip_dec && skip != 32'b0) begin
      skip <= skip - 1'b1;
    end
    if (cmd.rec_data) begin
      d_off  <= 32'(pos_plus);
      d_size <= asm_seq;
    end
    if (cmd.fmt_byte) begin
      case (cnt)
        FMT_IDX_AUDIO: f_audio    <= asm_fmt[15:0];
        FMT_IDX_CHAN:  f_chan     <= asm_fmt[15:0];
        FMT_IDX_RATE:  f_rate     <= asm_fmt;
        FMT_IDX_BRATE: decl_rate  <= asm_fmt;
        FMT_IDX_ALIGN: decl_align <= asm_fmt[15:0];
        FMT_IDX_BITS:  f_bits     <= asm_fmt[15:0];
        default: ;
      endcase
    end
    if (cmd.mul_prod) begin
      prod <= {16'b0, f_bits} * {16'b0, f_chan};
    end
    if (cmd.mul_rate) begin
      rprod <= prod * f_rate;
    end
  end

  // Result register: hold until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status        <= fin_status;
      format_tag    <= fin_ok ? f_audio : 16'b0;
      channel_count <= fin_ok ? f_chan  : 16'b0;
      sample_freq   <= fin_ok ? f_rate  : 32'b0;
      sample_bits   <= fin_ok ? f_bits  : 16'b0;
      data_offset   <= fin_ok ? d_off   : 32'b0;
      data_size     <= fin_ok ? d_size  : 32'b0;
    end
  end

  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result written while previous transaction pending");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (pos == '0 && cnt == 4'd0 && seen == 3'b0 && err == ST_OK))
    else $error("file state not cleared after final byte");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (sample_freq == 32'b0 && data_size == 32'b0 && format_tag == 16'b0))
    else $error("error result carries non-zero fields");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK && !$past(cmd.finish)) |=> (err == $past(err) || $past(cmd.finish)))
    else $error("latched error changed before end of file");

endmodule

### rtl/wavrp_ctrl.sv
// Controller: parse phase state machine and fmt check sequencing.
module wavrp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_eof,
  input  wavrp_pkg::sts_t sts,
  output logic            in_ready,
  output wavrp_pkg::cmd_t cmd
);
  import wavrp_pkg::*;

  typedef enum logic [2:0] {
    S_HEADER,
    S_FORM,
    S_FMT,
    S_SKIP,
    S_HALT,
    S_MUL1,
    S_MUL2,
    S_VERIFY
  } state_t;

  state_t state, state_next, phase_next;
  logic   pend_last, pend_last_next;
  logic   acc;

  always_comb begin
    case (state)
      S_HEADER, S_FORM, S_FMT, S_SKIP, S_HALT: in_ready = sts.slot_free;
      default:                                 in_ready = 1'b0;
    endcase
  end
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    phase_next     = state;
    pend_last_next = pend_last;
    case (state)
      S_HEADER: begin
        if (acc) begin
          cmd.hdr_byte = 1'b1;
          if (sts.hdr_done) begin
            if (sts.size_zero) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_ZERO_SIZE;
              phase_next   = S_HALT;
            end else if (sts.is_riff) begin
              phase_next = S_FORM;
            end else if (sts.is_fmt) begin
              cmd.load_skip_fmt = 1'b1;
              phase_next        = S_FMT;
            end else begin
              cmd.rec_data       = sts.is_data;
              cmd.load_skip_size = 1'b1;
              phase_next         = S_SKIP;
            end
          end
        end
      end
      S_FORM: begin
        if (acc) begin
          cmd.form_byte = 1'b1;
          if (sts.form_done) begin
            if (sts.is_wave) begin
              cmd.set_riff = 1'b1;
              phase_next   = S_HEADER;
            end else begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_NOT_WAVE;
              phase_next   = S_HALT;
            end
          end
        end
      end
      S_FMT: begin
        if (acc) begin
          cmd.fmt_byte = 1'b1;
          if (sts.fmt_done) begin
            pend_last_next = in_eof;
            phase_next     = S_MUL1;
          end
        end
      end
      S_SKIP: begin
        if (acc) begin
          cmd.skip_dec = 1'b1;
          if (sts.skip_le1) begin
            phase_next = S_HEADER;
          end
        end
      end
      S_MUL1: begin
        cmd.mul_prod = 1'b1;
        phase_next   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_rate = 1'b1;
        phase_next   = S_VERIFY;
      end
      S_VERIFY: begin
        if (!sts.rate_ok) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_RATE_BAD;
          phase_next   = S_HALT;
        end else if (!sts.align_ok) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_ALIGN_BAD;
          phase_next   = S_HALT;
        end else begin
          cmd.set_fmt = 1'b1;
          phase_next  = sts.skip_nz ? S_SKIP : S_HEADER;
        end
        if (pend_last) begin
          cmd.finish = 1'b1;
          cmd.trunc  = (phase_next != S_HEADER);
        end
      end
      default: ;
    endcase

    cmd.pos_inc = acc;
    state_next  = phase_next;
    // Report on the final byte, unless the fmt check still has to run.
    if (acc && in_eof && phase_next != S_MUL1) begin
      cmd.finish = 1'b1;
      cmd.trunc  = (phase_next != S_HEADER) || (state == S_HEADER && !sts.hdr_done);
    end
    if (cmd.finish) begin
      state_next     = S_HEADER;
      pend_last_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_HEADER;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      pend_last <= pend_last_next;
    end
  end

  a_check_stalls: assert property (@(posedge clk) disable iff (rst)
    (acc && state == S_FMT && sts.fmt_done) |=> (!in_ready ##1 !in_ready ##1 !in_ready))
    else $error("input taken during fmt check");

  a_pend_only_check: assert property (@(posedge clk) disable iff (rst)
    pend_last |-> (state == S_MUL1 || state == S_MUL2 || state == S_VERIFY))
    else $error("pending final byte outside fmt check");

endmodule

### rtl/wav_riff_header_parser_top.sv
// Top level of the WAV RIFF header parser.
//
//   channel  dir  payload                                           transaction
//   in_ch    in   stream_byte[7:0], end_of_file                     valid && ready
//   out_ch   out  status, format_tag, channel_count, sample_freq,   valid && ready
//                 sample_bits, data_offset, data_size
//
// One byte per cycle while the output register is free; after the last byte of an
// fmt chunk input stalls in S_MUL1 and S_MUL2 (two-step multiply) and S_VERIFY
// (byte rate and block align compare). A result is produced only for the byte flagged
// end_of_file: valid from the edge that takes it, or that leaves S_VERIFY when it
// closes an fmt chunk; held in an output register, it stalls input while unaccepted.
// After the final byte the parser is back in its reset state.
// Reset (rst, synchronous) clears the parse state and the output valid.
module wav_riff_header_parser_top (
  input  logic                  clk,
  input  logic                  rst,
  wavrp_byte_if.sink            in_ch,
  wavrp_result_if.source        out_ch
);
  import wavrp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wavrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_eof   (in_ch.end_of_file),
    .sts      (sts),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  wavrp_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_byte       (in_ch.stream_byte),
    .out_ready     (out_ch.ready),
    .sts           (sts),
    .out_valid     (out_ch.valid),
    .status        (out_ch.status),
    .format_tag    (out_ch.format_tag),
    .channel_count (out_ch.channel_count),
    .sample_freq   (out_ch.sample_freq),
    .sample_bits   (out_ch.sample_bits),
    .data_offset   (out_ch.data_offset),
    .data_size     (out_ch.data_size)
  );

endmodule

### tb/wav_riff_header_parser_top_tb.sv
// Self-checking testbench for the WAV RIFF header parser: directed and random files.
`timescale 1ns / 1ps

module wav_riff_header_parser_top_tb;
  import wavrp_pkg::*;

  typedef enum logic [2:0] {
    P_HEADER, P_FORM, P_FMT, P_SKIP, P_HALT
  } walk_phase_t;

  typedef enum {
    FLAW_NONE, FLAW_NOT_WAVE, FLAW_BAD_RATE, FLAW_BAD_ALIGN, FLAW_NO_RIFF,
    FLAW_TRUNCATE, FLAW_CORRUPT, FLAW_TRAILING
  } file_flaw_t;

  typedef enum {
    DRAIN_FREE, DRAIN_COIN, DRAIN_BURSTY, DRAIN_RARE_STALL
  } drain_mode_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_freq;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } wav_summary_t;

  typedef struct {
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] sample_freq;
    int          fmt_size;
    int          data_size;
    int          fmt_copies;
    int          data_copies;
    int          junk_before;
    bit          junk_after;
    bit          data_first;
    int          zero_hdr;
    file_flaw_t  flaw;
  } wave_plan_t;

  localparam logic [2:0] SAW_RIFF = 3'b001;
  localparam logic [2:0] SAW_FMT  = 3'b010;
  localparam logic [2:0] SAW_DATA = 3'b100;

  logic clk;
  logic rst;

  wavrp_byte_if   byte_ch ();
  wavrp_result_if result_ch ();

  wav_riff_header_parser_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch),
    .out_ch (result_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Parser walk state, mirrored from the byte stream
  walk_phase_t wav_phase;
  logic [4:0]  wav_count;
  logic [31:0] wav_word;
  logic [31:0] wav_tag;
  logic [31:0] wav_skip;
  logic [31:0] wav_pos;
  logic [31:0] wav_brate;
  logic [15:0] wav_align;
  logic [15:0] wav_audio;
  logic [15:0] wav_chan;
  logic [31:0] wav_rate;
  logic [15:0] wav_bits;
  logic [31:0] wav_data_off;
  logic [31:0] wav_data_len;
  logic [2:0]  wav_seen;
  logic [2:0]  wav_err;

  wav_summary_t expected_summaries[$];
  wav_summary_t want;

  logic [7:0]  file_bytes[$];
  int          headers_built;
  int          zeroed_header;
  int          feed_burst_left;
  int unsigned drain_tick;
  drain_mode_t drain_mode;
  int unsigned fail_count;
  int unsigned bytes_parsed;
  int unsigned files_sent;
  int unsigned results_seen;
  int unsigned status_hist[8];

  task automatic restart_wav_walk();
    wav_phase    = P_HEADER;
    wav_count    = '0;
    wav_word     = '0;
    wav_tag      = '0;
    wav_skip     = '0;
    wav_pos      = '0;
    wav_brate    = '0;
    wav_align    = '0;
    wav_audio    = '0;
    wav_chan     = '0;
    wav_rate     = '0;
    wav_bits     = '0;
    wav_data_off = '0;
    wav_data_len = '0;
    wav_seen     = '0;
    wav_err      = ST_OK;
  endtask

  task automatic latch_fault(input logic [2:0] code);
    if (wav_err == ST_OK)
      wav_err = code;
    wav_phase = P_HALT;
  endtask

  task automatic parse_wav_byte(input logic [7:0] b, input logic last);
    logic [31:0]  size_word;
    logic [3:0]   idx;
    logic [3:0]   first;
    logic [63:0]  prod;
    logic [63:0]  full;
    logic [2:0]   status;
    wav_summary_t res;

    case (wav_phase)
      P_HEADER: begin
        wav_word  = wav_word | (32'(b) << (8 * wav_count[1:0]));
        wav_count = wav_count + 1'b1;
        if (wav_count == 5'd4) begin
          wav_tag  = wav_word;
          wav_word = '0;
        end else if (wav_count >= 5'd8) begin
          size_word = wav_word;
          wav_word  = '0;
          wav_count = '0;
          // zero size wins over whatever the id says
          if (size_word == 32'd0) begin
            latch_fault(ST_ZERO_SIZE);
          end else if (wav_tag == TAG_RIFF) begin
            wav_phase = P_FORM;
          end else if (wav_tag == TAG_FMT) begin
            wav_skip  = (size_word > FMT_FIELD_BYTES) ? size_word - FMT_FIELD_BYTES : '0;
            wav_phase = P_FMT;
          end else begin
            if (wav_tag == TAG_DATA) begin
              wav_data_off = wav_pos + 1;
              wav_data_len = size_word;
              wav_seen     = wav_seen | SAW_DATA;
            end
            wav_skip  = size_word;
            wav_phase = P_SKIP;
          end
        end
      end
      P_FORM: begin
        wav_word  = wav_word | (32'(b) << (8 * wav_count[1:0]));
        wav_count = wav_count + 1'b1;
        if (wav_count >= 5'd4) begin
          size_word = wav_word;
          wav_word  = '0;
          wav_count = '0;
          if (size_word != TAG_WAVE) begin
            latch_fault(ST_NOT_WAVE);
          end else begin
            wav_seen  = wav_seen | SAW_RIFF;
            wav_phase = P_HEADER;
          end
        end
      end
      P_FMT: begin
        idx   = wav_count[3:0];
        first = (idx < 4'd2) ? 4'd0 : (idx < 4'd4) ? 4'd2 : (idx < 4'd8) ? 4'd4 :
                (idx < 4'd12) ? 4'd8 : (idx < 4'd14) ? 4'd12 : 4'd14;
        if (idx == first)
          wav_word = '0;
        wav_word  = wav_word | (32'(b) << (8 * (idx - first)));
        wav_count = wav_count + 1'b1;
        case (idx)
          4'd1:  wav_audio = wav_word[15:0];
          4'd3:  wav_chan  = wav_word[15:0];
          4'd7:  wav_rate  = wav_word;
          4'd11: wav_brate = wav_word;
          4'd13: wav_align = wav_word[15:0];
          4'd15: begin
            wav_bits  = wav_word[15:0];
            wav_word  = '0;
            wav_count = '0;
            // byte rate is checked before block align; product wraps at 32 bits
            prod = 64'(wav_bits) * 64'(wav_chan);
            full = prod * 64'(wav_rate);
            if (wav_brate != (full[31:0] >> 3)) begin
              latch_fault(ST_RATE_BAD);
            end else if (64'(wav_align) != (prod >> 3)) begin
              latch_fault(ST_ALIGN_BAD);
            end else begin
              wav_seen  = wav_seen | SAW_FMT;
              wav_phase = (wav_skip != 0) ? P_SKIP : P_HEADER;
            end
          end
          default: ;
        endcase
      end
      P_SKIP: begin
        if (wav_skip != 0)
          wav_skip = wav_skip - 1;
        if (wav_skip == 0)
          wav_phase = P_HEADER;
      end
      default: ;
    endcase
    wav_pos = wav_pos + 1;

    if (last) begin
      if (wav_err != ST_OK)
        status = wav_err;
      else if (wav_phase != P_HEADER || wav_count != 0)
        status = ST_TRUNCATED;
      else if (wav_seen != SEEN_ALL)
        status = ST_MISSING;
      else
        status = ST_OK;
      res        = '0;
      res.status = status;
      if (status == ST_OK) begin
        res.format_tag    = wav_audio;
        res.channel_count = wav_chan;
        res.sample_freq   = wav_rate;
        res.sample_bits   = wav_bits;
        res.data_offset   = wav_data_off;
        res.data_size     = wav_data_len;
      end
      expected_summaries.push_back(res);
      files_sent++;
      restart_wav_walk();
    end
  endtask

  // Mirror every accepted byte
  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      bytes_parsed++;
      parse_wav_byte(byte_ch.stream_byte, byte_ch.end_of_file);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_summaries.size() == 0) begin
        $error("result with status %0d arrived with none outstanding", result_ch.status);
        fail_count++;
      end else begin
        want = expected_summaries.pop_front();
        results_seen++;
        status_hist[want.status]++;
        compare_field("status", 32'(want.status), 32'(result_ch.status));
        compare_field("format_tag", 32'(want.format_tag), 32'(result_ch.format_tag));
        compare_field("channel_count", 32'(want.channel_count),
                      32'(result_ch.channel_count));
        compare_field("sample_freq", want.sample_freq, result_ch.sample_freq);
        compare_field("sample_bits", 32'(want.sample_bits), 32'(result_ch.sample_bits));
        compare_field("data_offset", want.data_offset, result_ch.data_offset);
        compare_field("data_size", want.data_size, result_ch.data_size);
      end
    end
  end

  // Result side: change stall behaviour every so often
  always @(negedge clk) begin
    drain_tick++;
    if (drain_tick % 97 == 0)
      drain_mode = drain_mode_t'($urandom_range(0, 3));
    case (drain_mode)
      DRAIN_FREE:   result_ch.ready <= 1'b1;
      DRAIN_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
      DRAIN_BURSTY: result_ch.ready <= ((drain_tick % 16) < 4);
      default:      result_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (feed_burst_left == 0) begin
      feed_burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    feed_burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.stream_byte <= b;
    byte_ch.end_of_file <= last;
    // hold until the transaction completes
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic push_word(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++)
      file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic push_random_bytes(input int n);
    repeat (n) file_bytes.push_back(8'($urandom));
  endtask

  task automatic push_chunk_header(input logic [31:0] tag, input logic [31:0] size);
    push_word(tag, 4);
    push_word((headers_built == zeroed_header) ? 32'd0 : size, 4);
    headers_built++;
  endtask

  task automatic push_junk_chunk();
    int n;
    n = $urandom_range(1, 8);
    push_chunk_header($urandom, n);
    push_random_bytes(n);
  endtask

  function automatic wave_plan_t base_plan();
    wave_plan_t p;
    p.format_tag    = 16'd1;
    p.channel_count = 16'd2;
    p.sample_bits   = 16'd16;
    p.sample_freq   = 32'd44100;
    p.fmt_size      = 16;
    p.data_size     = 8;
    p.fmt_copies    = 1;
    p.data_copies   = 1;
    p.junk_before   = 0;
    p.junk_after    = 1'b0;
    p.data_first    = 1'b0;
    p.zero_hdr      = -1;
    p.flaw          = FLAW_NONE;
    return p;
  endfunction

  task automatic run_wave_file(input wave_plan_t p);
    logic [15:0] a, c, bits, align;
    logic [31:0] r, brate;
    logic [63:0] prod, full;
    int          n;
    bit          final_copy;

    file_bytes.delete();
    headers_built = 0;
    zeroed_header = p.zero_hdr;
    if (p.flaw != FLAW_NO_RIFF) begin
      push_chunk_header(TAG_RIFF, $urandom_range(1, 32'hFFFF_FFFF));
      push_word((p.flaw == FLAW_NOT_WAVE) ? TAG_WAVE ^ $urandom_range(1, 32'hFFFF_FFFF)
                                          : TAG_WAVE, 4);
    end
    repeat (p.junk_before) push_junk_chunk();
    for (int slot = 0; slot < 2; slot++) begin
      if ((slot == 0) != p.data_first) begin
        for (int k = 0; k < p.fmt_copies; k++) begin
          final_copy = (k == p.fmt_copies - 1);
          if (final_copy) begin
            a = p.format_tag; c = p.channel_count; bits = p.sample_bits; r = p.sample_freq;
          end else begin
            a = 16'($urandom); c = 16'($urandom_range(1, 8));
            bits = 16'(8 * $urandom_range(1, 4)); r = $urandom;
          end
          prod  = 64'(bits) * 64'(c);
          full  = prod * 64'(r);
          brate = full[31:0] >> 3;
          align = 16'(prod >> 3);
          if (final_copy && p.flaw == FLAW_BAD_RATE) begin
            brate = brate + $urandom_range(1, 4096);
            align = align ^ 16'($urandom);
          end
          if (final_copy && p.flaw == FLAW_BAD_ALIGN)
            align = align ^ 16'($urandom_range(1, 65535));
          push_chunk_header(TAG_FMT, p.fmt_size);
          push_word(32'(a), 2);
          push_word(32'(c), 2);
          push_word(r, 4);
          push_word(brate, 4);
          push_word(32'(align), 2);
          push_word(32'(bits), 2);
          if (p.fmt_size > 16)
            push_random_bytes(p.fmt_size - 16);
        end
      end else begin
        for (int k = 0; k < p.data_copies; k++) begin
          n = (k == p.data_copies - 1) ? p.data_size : $urandom_range(1, 8);
          push_chunk_header(TAG_DATA, n);
          push_random_bytes(n);
        end
      end
    end
    if (p.junk_after)
      push_junk_chunk();
    case (p.flaw)
      FLAW_TRUNCATE: begin
        n = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end
      FLAW_CORRUPT:  file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
      FLAW_TRAILING: push_random_bytes($urandom_range(1, 10));
      default: ;
    endcase
    send_file();
  endtask

  task automatic test_clean_file();
    run_wave_file(base_plan());
  endtask

  task automatic test_status_codes();
    wave_plan_t p;
    p = base_plan(); p.flaw = FLAW_NOT_WAVE; run_wave_file(p);
    // zero size on the RIFF, fmt and data headers in turn
    for (int z = 0; z < 3; z++) begin
      p = base_plan(); p.zero_hdr = z; run_wave_file(p);
    end
    p = base_plan(); p.flaw = FLAW_BAD_RATE;  run_wave_file(p);
    p = base_plan(); p.flaw = FLAW_BAD_ALIGN; run_wave_file(p);
    p = base_plan(); p.fmt_copies = 0;        run_wave_file(p);
    p = base_plan(); p.data_copies = 0;       run_wave_file(p);
    p = base_plan(); p.flaw = FLAW_NO_RIFF;   run_wave_file(p);
    p = base_plan(); p.flaw = FLAW_TRUNCATE;  run_wave_file(p);
    file_bytes.delete();
    file_bytes.push_back(8'h52);
    send_file();
  endtask

  task automatic test_chunk_layouts();
    wave_plan_t p;
    p = base_plan(); p.fmt_size = 4; run_wave_file(p);
    p = base_plan(); p.fmt_size = 22; p.junk_before = 2; p.junk_after = 1'b1;
    run_wave_file(p);
    // file ends on the last fmt byte, so the rate check runs on the final byte
    p = base_plan(); p.data_first = 1'b1; run_wave_file(p);
    p = base_plan(); p.fmt_copies = 2; p.data_copies = 2; run_wave_file(p);
    p = base_plan(); p.flaw = FLAW_TRAILING; run_wave_file(p);
  endtask

  task automatic test_field_extremes();
    wave_plan_t p;
    p = base_plan();
    p.format_tag = 16'hFFFF; p.channel_count = 16'hFFFF;
    p.sample_bits = 16'h0; p.sample_freq = 32'hFFFF_FFFF;
    run_wave_file(p);
    p = base_plan();
    p.format_tag = 16'h0; p.channel_count = 16'h0;
    p.sample_bits = 16'hFFFF; p.sample_freq = 32'h0; p.data_size = 1;
    run_wave_file(p);
    p = base_plan();
    p.channel_count = 16'hFFFF; p.sample_bits = 16'hFFFF;
    run_wave_file(p);
    p = base_plan();
    p.channel_count = 16'd1; p.sample_bits = 16'd8; p.sample_freq = 32'hFFFF_FFFF;
    run_wave_file(p);
  endtask

  task automatic test_random_files();
    wave_plan_t  p;
    int unsigned rnd_bytes;
    int unsigned rnd_files;
    int          pick;

    rnd_bytes = 0;
    rnd_files = 0;
    while (rnd_bytes < 600 || rnd_files < 8) begin
      p = base_plan();
      p.format_tag = $urandom_range(0, 1) ? 16'd1 : 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        p.channel_count = 16'($urandom);
        p.sample_bits   = 16'($urandom);
      end else begin
        p.channel_count = 16'($urandom_range(1, 8));
        p.sample_bits   = $urandom_range(0, 1) ? 16'(8 * $urandom_range(1, 4))
                                               : 16'($urandom_range(0, 64));
      end
      p.sample_freq = $urandom_range(0, 1) ? $urandom : $urandom_range(8000, 192000);
      pick = $urandom_range(0, 9);
      p.fmt_size = (pick < 7) ? 16 : (pick < 9) ? $urandom_range(17, 24)
                                                : $urandom_range(1, 15);
      p.data_size   = $urandom_range(1, 24);
      pick = $urandom_range(0, 19);
      p.fmt_copies  = (pick == 0) ? 0 : (pick < 3) ? 2 : 1;
      pick = $urandom_range(0, 19);
      p.data_copies = (pick == 0) ? 0 : (pick < 3) ? 2 : 1;
      p.junk_before = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      p.junk_after  = ($urandom_range(0, 4) == 0);
      p.data_first  = ($urandom_range(0, 9) < 3);
      case ($urandom_range(0, 19))
        11:      p.flaw = FLAW_NOT_WAVE;
        12:      p.zero_hdr = $urandom_range(0, 4);
        13:      p.flaw = FLAW_BAD_RATE;
        14:      p.flaw = FLAW_BAD_ALIGN;
        15:      p.flaw = FLAW_NO_RIFF;
        16, 17:  p.flaw = FLAW_TRUNCATE;
        18:      p.flaw = FLAW_CORRUPT;
        19:      p.flaw = FLAW_TRAILING;
        default: p.flaw = FLAW_NONE;
      endcase
      run_wave_file(p);
      rnd_bytes += file_bytes.size();
      rnd_files++;
    end
  endtask

  initial begin
    rst                 = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.stream_byte = 8'h00;
    byte_ch.end_of_file = 1'b0;
    result_ch.ready     = 1'b0;
    feed_burst_left     = 0;
    drain_tick          = 0;
    drain_mode          = DRAIN_FREE;
    fail_count          = 0;
    bytes_parsed        = 0;
    files_sent          = 0;
    results_seen        = 0;
    foreach (status_hist[i]) status_hist[i] = 0;
    restart_wav_walk();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clean_file();
    test_status_codes();
    test_chunk_layouts();
    test_field_extremes();
    test_random_files();

    @(negedge clk);
    byte_ch.valid <= 1'b0;
    for (int n = 0; n < 20000 && expected_summaries.size() != 0; n++)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_summaries.size() != 0) begin
      $error("%0d results never arrived", expected_summaries.size());
      fail_count++;
    end

    $display("Parsed %0d files in %0d bytes, %0d results checked", files_sent,
             bytes_parsed, results_seen);
    $display("Statuses: ok %0d, not wave %0d, zero size %0d, rate %0d, align %0d, %s%0d, %s%0d",
             status_hist[ST_OK], status_hist[ST_NOT_WAVE], status_hist[ST_ZERO_SIZE],
             status_hist[ST_RATE_BAD], status_hist[ST_ALIGN_BAD], "missing ",
             status_hist[ST_MISSING], "truncated ", status_hist[ST_TRUNCATED]);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #4_000_000;
    $error("run timed out");
    $display("FAIL");
    $finish;
  end

endmodule
